@@ design/u2pw_pkg.sv @@
// Package: shared types and constants for the UTF-8 to WinAnsi PDF string escaper.
`timescale 1ns / 1ps
package u2pw_pkg;

  // Work kinds handed from the front to the back
  typedef enum logic [2:0] {
    OP_NONE,   // nothing to emit
    OP_CHAR,   // one character as is
    OP_ESC,    // backslash, then the character
    OP_TAB,    // four spaces
    OP_OCT     // backslash and three octal digits of the value
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] val;
  } tok_t;

  // Queue entry: a token plus the flag for the last beat of its input byte
  typedef struct packed {
    tok_t tok;
    logic last;
  } qtok_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] ChQmark = 8'h3F;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSpace = 8'h20;

endpackage

@@ design/u2pw_front.sv @@
// Front end: UTF-8 sequence tracking and token classification.
`timescale 1ns / 1ps
module u2pw_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  output logic             q_push_o,
  output u2pw_pkg::qtok_t  q_tok_o,
  input  logic             q_full_i
);
  import u2pw_pkg::*;

  typedef struct packed {
    tok_t [3:0] toks;
    logic [2:0] cnt;
  } tail_t;

  localparam tok_t TokNone  = '{op: OP_NONE, val: 8'h00};
  localparam tok_t TokQmark = '{op: OP_CHAR, val: ChQmark};

  // Number of following bytes for a lead byte; zero when unusable
  function automatic logic [1:0] lead_len(input logic [7:0] c);
    logic [1:0] r;
    if ((c & 8'hE0) == 8'hC0)      r = 2'd1;
    else if ((c & 8'hF0) == 8'hE0) r = 2'd2;
    else if ((c & 8'hF8) == 8'hF0) r = 2'd3;
    else                           r = 2'd0;
    return r;
  endfunction

  function automatic logic [20:0] lead_bits(input logic [7:0] c, input logic [1:0] k);
    logic [20:0] r;
    if (k == 2'd1)      r = {16'd0, c[4:0]};
    else if (k == 2'd2) r = {17'd0, c[3:0]};
    else                r = {18'd0, c[2:0]};
    return r;
  endfunction

  // ASCII and control bytes
  function automatic tok_t plain_tok(input logic [7:0] c);
    tok_t r;
    if (c == 8'h5C || c == 8'h28 || c == 8'h29) r = '{op: OP_ESC, val: c};
    else if (c >= 8'h20 && c <= 8'h7E)        r = '{op: OP_CHAR, val: c};
    else if (c == 8'h09)                        r = '{op: OP_TAB, val: c};
    else                                        r = TokNone;
    return r;
  endfunction

  // Finished code point to WinAnsi
  function automatic tok_t map_code(input logic [20:0] cp);
    tok_t r;
    if (cp >= 21'h0000A0 && cp <= 21'h0000FF) begin
      r = '{op: OP_OCT, val: cp[7:0]};
    end else begin
      case (cp)
        21'h002014: r = '{op: OP_OCT, val: 8'h97};
        21'h002013: r = '{op: OP_OCT, val: 8'h96};
        21'h00201C: r = '{op: OP_OCT, val: 8'h93};
        21'h00201D: r = '{op: OP_OCT, val: 8'h94};
        21'h002018: r = '{op: OP_OCT, val: 8'h91};
        21'h002019: r = '{op: OP_OCT, val: 8'h92};
        21'h002022: r = '{op: OP_OCT, val: 8'h95};
        21'h002026: r = '{op: OP_OCT, val: 8'h85};
        default:    r = TokQmark;
      endcase
    end
    return r;
  endfunction

  // Truncated sequence: '?' then the held bytes re-run as a short string
  function automatic tail_t run_tail(input logic [7:0] b0, input logic [7:0] b1,
                                     input logic [7:0] b2, input logic [1:0] len);
    logic [7:0]  t [5];
    tail_t       r;
    logic [1:0]  skip;
    logic [1:0]  k;
    logic [20:0] cp;
    tok_t        tk;
    t[0] = b0;
    t[1] = b1;
    t[2] = b2;
    t[3] = 8'h00;
    t[4] = 8'h00;
    r.toks = '0;
    r.toks[0] = TokQmark;
    r.cnt = 3'd1;
    skip = 2'd0;
    for (int i = 0; i < 3; i++) begin
      tk = TokNone;
      if (skip != 2'd0) begin
        skip = skip - 2'd1;
      end else if (i < int'(len)) begin
        if (t[i] >= 8'hC0) begin
          k = lead_len(t[i]);
          if (k != 2'd0 && (i + int'(k)) < int'(len)) begin
            if (k == 2'd1) cp = {10'd0, t[i][4:0], t[i+1][5:0]};
            else           cp = {5'd0, t[i][3:0], t[i+1][5:0], t[i+2][5:0]};
            tk = map_code(cp);
            skip = k;
          end else begin
            tk = TokQmark;
          end
        end else begin
          tk = plain_tok(t[i]);
        end
      end
      if (tk.op != OP_NONE) begin
        r.toks[r.cnt[1:0]] = tk;
        r.cnt = r.cnt + 3'd1;
      end
    end
    return r;
  endfunction

  logic [1:0]  needed_q, needed_d;
  logic [20:0] accum_q, accum_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic [7:0]  held1_q, held1_d, held2_q, held2_d;
  tok_t [3:0]  pend_q, pend_d;
  logic [2:0]  pcnt_q, pcnt_d;
  logic [1:0]  pidx_q, pidx_d;

  logic        accept;
  logic [20:0] acc_n;
  logic [1:0]  nd;
  logic [1:0]  llen;
  tok_t        ptok;
  tail_t       tl;
  logic [7:0]  tb0, tb1, tb2;
  logic [1:0]  tlen;

  assign in_stall_o = (pcnt_q != 3'd0) || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign acc_n      = {accum_q[14:0], in_byte_i[5:0]};
  assign nd         = needed_q - 2'd1;
  assign llen       = lead_len(in_byte_i);
  assign ptok       = plain_tok(in_byte_i);

  // Assemble the tail string from held following bytes and the final byte
  always_comb begin
    tb0  = in_byte_i;
    tb1  = 8'h00;
    tb2  = 8'h00;
    tlen = 2'd1;
    case (hcnt_q)
      2'd2: begin
        tb0 = held1_q; tb1 = in_byte_i; tlen = 2'd2;
      end
      2'd3: begin
        tb0 = held1_q; tb1 = held2_q; tb2 = in_byte_i; tlen = 2'd3;
      end
      default: begin
        tb0 = in_byte_i;
      end
    endcase
  end

  assign tl = run_tail(tb0, tb1, tb2, tlen);

  // Sequence tracking and token generation
  always_comb begin
    needed_d = needed_q;
    accum_d  = accum_q;
    hcnt_d   = hcnt_q;
    held1_d  = held1_q;
    held2_d  = held2_q;
    pend_d   = pend_q;
    pcnt_d   = pcnt_q;
    pidx_d   = pidx_q;
    q_push_o = 1'b0;
    q_tok_o  = '{tok: TokNone, last: 1'b1};

    if (pcnt_q != 3'd0) begin
      // drain the tail tokens, one per cycle while the queue is not full
      if (!q_full_i) begin
        q_push_o = 1'b1;
        q_tok_o.tok  = pend_q[pidx_q];
        q_tok_o.last = ({1'b0, pidx_q} == pcnt_q - 3'd1);
        if (q_tok_o.last) begin
          pcnt_d = 3'd0;
          pidx_d = 2'd0;
        end else begin
          pidx_d = pidx_q + 2'd1;
        end
      end
    end else if (accept) begin
      if (needed_q == 2'd0) begin
        if (in_byte_i >= 8'hC0) begin
          if (llen == 2'd0 || in_last_i) begin
            q_push_o    = 1'b1;
            q_tok_o.tok = TokQmark;
          end else begin
            needed_d = llen;
            accum_d  = lead_bits(in_byte_i, llen);
            hcnt_d   = 2'd1;
          end
        end else begin
          q_push_o    = (ptok.op != OP_NONE);
          q_tok_o.tok = ptok;
        end
      end else begin
        accum_d  = acc_n;
        needed_d = nd;
        if (nd == 2'd0) begin
          q_push_o    = 1'b1;
          q_tok_o.tok = map_code(acc_n);
          accum_d     = '0;
          hcnt_d      = 2'd0;
        end else if (in_last_i) begin
          pend_d   = tl.toks;
          pcnt_d   = tl.cnt;
          pidx_d   = 2'd0;
          needed_d = 2'd0;
          accum_d  = '0;
          hcnt_d   = 2'd0;
        end else if (hcnt_q == 2'd1) begin
          held1_d = in_byte_i;
          hcnt_d  = 2'd2;
        end else if (hcnt_q == 2'd2) begin
          held2_d = in_byte_i;
          hcnt_d  = 2'd3;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needed_q <= '0;
      accum_q  <= '0;
      hcnt_q   <= '0;
      pcnt_q   <= '0;
      pidx_q   <= '0;
    end else begin
      needed_q <= needed_d;
      accum_q  <= accum_d;
      hcnt_q   <= hcnt_d;
      pcnt_q   <= pcnt_d;
      pidx_q   <= pidx_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    held1_q <= held1_d;
    held2_q <= held2_d;
    pend_q  <= pend_d;
  end

endmodule

@@ design/u2pw_queue.sv @@
// Token queue between the front and back ends.
`timescale 1ns / 1ps
module u2pw_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  u2pw_pkg::qtok_t  push_tok_i,
  output logic             full_o,
  input  logic             pop_i,
  output u2pw_pkg::qtok_t  pop_tok_o,
  output logic             empty_o
);
  import u2pw_pkg::*;

  qtok_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o    = (cnt_q == QCntW'(QDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_tok_o = mem_q[rd_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_tok_i;
  end

endmodule

@@ design/u2pw_back.sv @@
// Back end: expands tokens into output characters, one beat per cycle unless the output stalls.
`timescale 1ns / 1ps
module u2pw_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  u2pw_pkg::qtok_t  q_tok_i,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_char_o,
  output logic             out_last_o
);
  import u2pw_pkg::*;

  qtok_t      cur_q;
  logic       cur_vld_q;
  logic [1:0] step_q;
  logic       ovld_q;
  logic [7:0] ochar_q;
  logic       olast_q;

  logic       out_load;
  logic       done;
  logic [1:0] nstep;
  logic [7:0] ch;

  // Steps per token and the character at the current step
  always_comb begin
    nstep = 2'd0;
    ch    = cur_q.tok.val;
    case (cur_q.tok.op)
      OP_ESC: begin
        nstep = 2'd1;
        ch    = (step_q == 2'd0) ? ChBslash : cur_q.tok.val;
      end
      OP_TAB: begin
        nstep = 2'd3;
        ch    = ChSpace;
      end
      OP_OCT: begin
        nstep = 2'd3;
        case (step_q)
          2'd0:    ch = ChBslash;
          2'd1:    ch = {6'b001100, cur_q.tok.val[7:6]};
          2'd2:    ch = {5'b00110, cur_q.tok.val[5:3]};
          default: ch = {5'b00110, cur_q.tok.val[2:0]};
        endcase
      end
      default: begin
        nstep = 2'd0;
        ch    = cur_q.tok.val;
      end
    endcase
  end

  assign out_load = cur_vld_q && (!ovld_q || !out_stall_i);
  assign done     = (step_q == nstep);
  assign q_pop_o  = !q_empty_i && (!cur_vld_q || (out_load && done));

  // Current token, step counter and output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      step_q    <= '0;
      ovld_q    <= 1'b0;
    end else begin
      if (q_pop_o) begin
        cur_vld_q <= 1'b1;
        step_q    <= '0;
      end else if (out_load) begin
        if (done) begin
          cur_vld_q <= 1'b0;
          step_q    <= '0;
        end else begin
          step_q <= step_q + 2'd1;
        end
      end
      if (out_load)          ovld_q <= 1'b1;
      else if (!out_stall_i) ovld_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_tok_i;
    if (out_load) begin
      ochar_q <= ch;
      olast_q <= cur_q.last && done;
    end
  end

  assign out_valid_o = ovld_q;
  assign out_char_o  = ochar_q;
  assign out_last_o  = olast_q;

endmodule

@@ design/utf8_to_pdf_winansi_escaper_core.sv @@
// Top level: UTF-8 to WinAnsi PDF string escaper core.
// A byte's first character passes the queue, the current token and the output register.
// Throughput: one output character per cycle unless out_stall_i is high; a token expands
// to 1 to 4 characters by the back end's step counter (tab and octal escape give 4).
// A cut string holds the input while its tail tokens drain and while the queue is full.
// Reset (rst_ni, asynchronous, active low) clears sequence, queue and output state.
`timescale 1ns / 1ps
module utf8_to_pdf_winansi_escaper_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);
  import u2pw_pkg::*;

  logic  q_push, q_full, q_pop, q_empty;
  qtok_t q_push_tok, q_pop_tok;

  u2pw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_push_o   (q_push),
    .q_tok_o    (q_push_tok),
    .q_full_i   (q_full)
  );

  u2pw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_tok_i (q_push_tok),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_tok_o  (q_pop_tok),
    .empty_o    (q_empty)
  );

  u2pw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_tok_i     (q_pop_tok),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o)
  );

  // The front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("token pushed into full queue");

  // The back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty))
    else $error("token popped from empty queue");

  // Queued tokens always carry real work
  a_tok_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_push_tok.tok.op != OP_NONE))
    else $error("empty token queued");

endmodule
